### sv/skaf_pkg.sv
// Shared types and constants for the scalar Kalman angle filter core.
// Used by skaf_mul, skaf_div and scalar_kalman_angle_filter_core.
package skaf_pkg;

	localparam int ANGLE_W = 32;
	localparam int VAR_W   = 32;
	localparam int GAIN_W  = 16;
	localparam int SP_W    = 16;
	localparam int NOISE_W = 24;
	localparam int CFG_W   = 24;
	localparam int CFG_A_W = 2;

	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [CFG_A_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
	localparam logic [CFG_A_W-1:0] REG_PROCESS_NOISE = 2'd1;
	localparam logic [CFG_A_W-1:0] REG_MEAS_VARIANCE = 2'd2;

	localparam logic [SP_W-1:0]    SP_RESET    = 16'd262;
	localparam logic [NOISE_W-1:0] NOISE_RESET = 24'd65536;
	localparam logic [NOISE_W-1:0] MV_RESET    = 24'd589824;

	typedef struct packed {
		logic             start;
		logic [VAR_W-1:0] num;
		logic [VAR_W:0]   den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [GAIN_W-1:0] gain;
	} div_rsp_t;

endpackage

### sv/skaf_mul.sv
// Shared signed multiplier with registered product.
// Depends on skaf_pkg for operand widths.
module skaf_mul (
	input  logic                                  clk,
	input  logic signed [skaf_pkg::MUL_A_W-1:0]   a,
	input  logic signed [skaf_pkg::MUL_B_W-1:0]   b,
	output logic signed [skaf_pkg::MUL_P_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

### sv/skaf_div.sv
// Restoring bit-serial divider for the gain: floor(num * 2^16 / den), clipped to 16 bits.
// Depends on skaf_pkg for the request/response structs.
module skaf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  skaf_pkg::div_req_t req,
	output skaf_pkg::div_rsp_t rsp
);

	localparam int QW   = skaf_pkg::GAIN_W + 1;
	localparam int RW   = skaf_pkg::VAR_W + 2;
	localparam int CW   = $clog2(QW + 1);

	logic [RW-1:0]                rem_q;
	logic [skaf_pkg::VAR_W:0]     den_q;
	logic [QW-1:0]                quo_q;
	logic [CW-1:0]                cnt_q;
	logic                         busy_q;
	logic                         zero_q;
	logic                         done_q;
	logic                         ge;
	logic [RW-1:0]                diff;
	logic [RW-1:0]                rem_nx;

	assign ge     = rem_q >= {1'b0, den_q};
	assign diff   = rem_q - {1'b0, den_q};
	assign rem_nx = ge ? {diff[RW-2:0], 1'b0} : {rem_q[RW-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {2'b00, req.num};
			den_q  <= req.den;
			zero_q <= (req.den == '0);
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (zero_q)
			rsp.gain = '0;
		else if (quo_q[QW-1])
			rsp.gain = '1;
		else
			rsp.gain = quo_q[QW-2:0];
	end

endmodule

### sv/scalar_kalman_angle_filter_core.sv
// One-dimensional Kalman filter for an angle, Q16.16 fixed point. Each input word
// (measured angle, angular rate) yields one output word (filtered angle, variance).
// The core takes one word at a time: its work goes to three passes through one shared
// 34x18 multiplier, a 17-step bit-serial gain divider and the sequencer steps around
// them. s_tready is low from an accepted input word until the sequencer is back in idle.
// A held output word stalls the sequencer in its last step.
// Configuration writes are taken any time and should be made while the block is idle.
module scalar_kalman_angle_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] measured_angle, [63:32] angular_rate
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] filtered_angle, [63:32] error_variance
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);

	localparam int AW = skaf_pkg::ANGLE_W;
	localparam int VW = skaf_pkg::VAR_W;
	localparam int PW = skaf_pkg::MUL_P_W;
	localparam int SW = PW - 15;
	localparam int TW = SW + 1;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MULD  = 4'd1;
	localparam logic [3:0] ST_PRED  = 4'd2;
	localparam logic [3:0] ST_DIVGO = 4'd3;
	localparam logic [3:0] ST_DIVW  = 4'd4;
	localparam logic [3:0] ST_MULI  = 4'd5;
	localparam logic [3:0] ST_CORR  = 4'd6;
	localparam logic [3:0] ST_MULP  = 4'd7;
	localparam logic [3:0] ST_PUPD  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0]                     state_q;
	logic [skaf_pkg::SP_W-1:0]      sp_q;
	logic [skaf_pkg::NOISE_W-1:0]   noise_q;
	logic [skaf_pkg::NOISE_W-1:0]   mv_q;
	logic signed [AW-1:0]           angle_q;
	logic [VW-1:0]                  var_q;
	logic signed [AW-1:0]           meas_q;
	logic signed [AW-1:0]           rate_q;
	logic [skaf_pkg::GAIN_W-1:0]    gain_q;
	logic                           m_tvalid_q;
	logic [63:0]                    m_tdata_q;

	logic signed [skaf_pkg::MUL_A_W-1:0] mul_a;
	logic signed [skaf_pkg::MUL_B_W-1:0] mul_b;
	logic signed [PW-1:0]                prod_q;
	skaf_pkg::div_req_t                  div_req;
	skaf_pkg::div_rsp_t                  div_rsp;

	logic signed [PW:0]   rnd;
	logic signed [SW-1:0] step;
	logic signed [TW-1:0] ang_sum;
	logic signed [AW-1:0] ang_sat;
	logic [VW:0]          var_sum;
	logic [VW-1:0]        var_pred;

	function automatic logic signed [AW-1:0] sat_angle(input logic signed [TW-1:0] x);
		logic signed [TW-1:0] hi;
		logic signed [TW-1:0] lo;
		begin
			hi = TW'({1'b0, {(AW-1){1'b1}}});
			lo = -hi - TW'(1);
			if (x > hi)
				sat_angle = {1'b0, {(AW-1){1'b1}}};
			else if (x < lo)
				sat_angle = {1'b1, {(AW-1){1'b0}}};
			else
				sat_angle = x[AW-1:0];
		end
	endfunction

	skaf_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	skaf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		case (state_q)
			ST_MULD: begin
				mul_a = skaf_pkg::MUL_A_W'(rate_q);
				mul_b = {2'b00, sp_q};
			end
			ST_MULI: begin
				mul_a = skaf_pkg::MUL_A_W'(meas_q) - skaf_pkg::MUL_A_W'(angle_q);
				mul_b = {2'b00, gain_q};
			end
			ST_MULP: begin
				mul_a = {2'b00, var_q};
				mul_b = skaf_pkg::MUL_B_W'(18'd65536 - {2'b00, gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign rnd      = {prod_q[PW-1], prod_q} + (PW+1)'(32768);
	assign step     = rnd[PW:16];
	assign ang_sum  = TW'(angle_q) + TW'(step);
	assign ang_sat  = sat_angle(ang_sum);
	assign var_sum  = {1'b0, var_q} + (VW+1)'(noise_q);
	assign var_pred = var_sum[VW] ? '1 : var_sum[VW-1:0];

	assign div_req.start = (state_q == ST_DIVGO);
	assign div_req.num   = var_q;
	assign div_req.den   = {1'b0, var_q} + (VW+1)'(mv_q);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= skaf_pkg::SP_RESET;
			noise_q <= skaf_pkg::NOISE_RESET;
			mv_q    <= skaf_pkg::MV_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				skaf_pkg::REG_SAMPLE_PERIOD: sp_q    <= cfg_wdata[skaf_pkg::SP_W-1:0];
				skaf_pkg::REG_PROCESS_NOISE: noise_q <= cfg_wdata;
				skaf_pkg::REG_MEAS_VARIANCE: mv_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			angle_q    <= '0;
			var_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE:  if (s_tvalid) state_q <= ST_MULD;
				ST_MULD:  state_q <= ST_PRED;
				ST_PRED: begin
					angle_q <= ang_sat;
					var_q   <= var_pred;
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: state_q <= ST_DIVW;
				ST_DIVW:  if (div_rsp.done) state_q <= ST_MULI;
				ST_MULI:  state_q <= ST_CORR;
				ST_CORR: begin
					angle_q <= ang_sat;
					state_q <= ST_MULP;
				end
				ST_MULP:  state_q <= ST_PUPD;
				ST_PUPD: begin
					var_q   <= rnd[VW+15:16];
					state_q <= ST_OUT;
				end
				ST_OUT:   if (!m_tvalid_q || m_tready) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			meas_q <= s_tdata[31:0];
			rate_q <= s_tdata[63:32];
		end
		if (state_q == ST_DIVW && div_rsp.done)
			gain_q <= div_rsp.gain;
		if (state_q == ST_OUT && (!m_tvalid_q || m_tready))
			m_tdata_q <= {var_q, angle_q};
	end

endmodule

### tb/skaf_filter_check.sv
// Checker for scalar_kalman_angle_filter_core: tracks config writes, predicts each
// output word with its own fixed-point Kalman update and compares field by field.
// Depends on skaf_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module skaf_filter_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_wdata,
	output int          mismatch_count,
	output int          pending
);

	typedef struct packed {
		logic [skaf_pkg::VAR_W-1:0]   variance;
		logic [skaf_pkg::ANGLE_W-1:0] angle;
	} filt_word_t;

	localparam longint ANGLE_MAX = (64'sd1 <<< 31) - 1;
	localparam longint ANGLE_MIN = -(64'sd1 <<< 31);
	localparam longint VAR_MAX   = (64'sd1 <<< 32) - 1;
	localparam longint GAIN_MAX  = 65535;
	localparam longint ONE_Q16   = 65536;
	localparam longint HALF_Q16  = 32768;

	logic [skaf_pkg::SP_W-1:0]           period_r;
	logic [skaf_pkg::NOISE_W-1:0]        noise_r;
	logic [skaf_pkg::NOISE_W-1:0]        mvar_r;
	logic signed [skaf_pkg::ANGLE_W-1:0] angle_st;
	logic [skaf_pkg::VAR_W-1:0]          var_st;
	filt_word_t                          pending_estimates[$];

	function automatic longint sat_angle(input longint x);
		if (x > ANGLE_MAX)
			return ANGLE_MAX;
		if (x < ANGLE_MIN)
			return ANGLE_MIN;
		return x;
	endfunction

	// x / 2^16, round half up
	function automatic longint round_q16(input longint x);
		return (x + HALF_Q16) >>> 16;
	endfunction

	function automatic filt_word_t kalman_update(input logic [31:0] meas_bits,
			input logic [31:0] rate_bits);
		longint meas, rate, ang, p, den, g;
		meas = longint'($signed(meas_bits));
		rate = longint'($signed(rate_bits));
		ang = sat_angle(longint'(angle_st) + round_q16(rate * longint'(period_r)));
		p = longint'(var_st) + longint'(noise_r);
		if (p > VAR_MAX)
			p = VAR_MAX;
		den = p + longint'(mvar_r);
		if (den == 0)
			g = 0;
		else
			g = (p <<< 16) / den;
		if (g > GAIN_MAX)
			g = GAIN_MAX;
		ang = sat_angle(ang + round_q16((meas - ang) * g));
		p = (p * (ONE_Q16 - g) + HALF_Q16) >>> 16;
		angle_st = ang[31:0];
		var_st = p[31:0];
		return '{variance: p[31:0], angle: ang[31:0]};
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	initial mismatch_count = 0;

	always @(posedge clk or negedge arst_n) begin
		filt_word_t got_w, want_w;
		if (!arst_n) begin
			period_r = skaf_pkg::SP_RESET;
			noise_r = skaf_pkg::NOISE_RESET;
			mvar_r = skaf_pkg::MV_RESET;
			angle_st = '0;
			var_st = '0;
			pending_estimates.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					skaf_pkg::REG_SAMPLE_PERIOD:
						period_r = cfg_wdata[skaf_pkg::SP_W-1:0];
					skaf_pkg::REG_PROCESS_NOISE:
						noise_r = cfg_wdata[skaf_pkg::NOISE_W-1:0];
					skaf_pkg::REG_MEAS_VARIANCE:
						mvar_r = cfg_wdata[skaf_pkg::NOISE_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got_w = m_tdata;
				if (pending_estimates.size() == 0) begin
					report_mismatch("output word with no prediction", m_tdata, 'x);
				end else begin
					want_w = pending_estimates.pop_front();
					if (got_w.angle !== want_w.angle)
						report_mismatch("filtered_angle", {32'h0, got_w.angle},
							{32'h0, want_w.angle});
					if (got_w.variance !== want_w.variance)
						report_mismatch("error_variance", {32'h0, got_w.variance},
							{32'h0, want_w.variance});
				end
			end
			if (s_tvalid && s_tready)
				pending_estimates.push_back(kalman_update(s_tdata[31:0], s_tdata[63:32]));
			pending <= pending_estimates.size();
		end
	end

endmodule

### tb/tb.sv
// Testbench top for scalar_kalman_angle_filter_core: clock, reset, config writes,
// directed and random angle/rate words, random backpressure and the verdict.
// Depends on skaf_pkg, the core and skaf_filter_check.
`timescale 1ns / 1ps

module tb;

	localparam logic [skaf_pkg::CFG_A_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASES        = 6;
	localparam int PHASE_WORDS   = 82;
	localparam int DRAIN_CYCLES  = 60;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [23:0] cfg_wdata;

	int mismatch_count;
	int pending;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;

	scalar_kalman_angle_filter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	skaf_filter_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.mismatch_count(mismatch_count),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// pending is registered, so the first wait lets a word just taken show up in it
	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] sp, input logic [23:0] pn,
			input logic [23:0] mv);
		s_tvalid <= 1'b0;
		drain();
		cfg_write(skaf_pkg::REG_SAMPLE_PERIOD, {8'h00, sp});
		cfg_write(skaf_pkg::REG_PROCESS_NOISE, pn);
		cfg_write(skaf_pkg::REG_MEAS_VARIANCE, mv);
		cfg_we <= 1'b0;
	endtask

	// s_tvalid stays high after a word so back-to-back words need no toggle
	task automatic send_word(input logic [31:0] meas, input logic [31:0] rate);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rate, meas};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// receiver: random stall bursts, one long hold on request
	initial begin
		m_tready = 1'b0;
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int true_ang, rate_v, noise_v, sel;
		logic [15:0] sp;
		logic [23:0] pn, mv;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		true_ang = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out-of-range index is ignored; zero noise and zero meas variance give P+R = 0
		cfg_write(REG_UNUSED, 24'hFFFFFF);
		set_config(skaf_pkg::SP_RESET, 24'h000000, 24'h000000);
		send_word(32'h1234_0000, 32'h0001_0000);
		send_word(32'h8000_0000, 32'h7FFF_FFFF);

		// zero meas variance with noise: gain pinned just under one; angle saturation
		set_config(16'hFFFF, 24'hFFFFFF, 24'h000000);
		send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(32'h8000_0000, 32'h8000_0000);
		send_word(32'h8000_0000, 32'h8000_0000);
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'hFFFF_FFFF, 32'h0000_0001);

		// zero sample period, tiny variances
		set_config(16'h0000, 24'h000001, 24'h000001);
		send_word(32'h5555_5555, 32'hAAAA_AAAA);
		send_word(32'hAAAA_AAAA, 32'h5555_5555);

		// huge variance against tiny noise, then back to reset values
		set_config(16'h0001, 24'h000001, 24'hFFFFFF);
		send_word(32'h0064_0000, 32'hFF9C_0000);
		send_word(32'h7FFF_FFFF, 32'h8000_0000);
		set_config(skaf_pkg::SP_RESET, skaf_pkg::NOISE_RESET, skaf_pkg::MV_RESET);
		send_word(32'h000A_0000, 32'h0002_0000);
		send_word(32'hFFF6_0000, 32'hFFFE_0000);
		send_word(32'h0000_8000, 32'h0000_0000);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					sp = skaf_pkg::SP_RESET;
					pn = skaf_pkg::NOISE_RESET;
					mv = skaf_pkg::MV_RESET;
				end
				1: begin sp = 16'hFFFF; pn = 24'hFFFFFF; mv = 24'hFFFFFF; end
				2: begin sp = 16'h0001; pn = 24'h000000; mv = 24'h000001; end
				default: begin
					sp = 16'($urandom_range(1, 16'hFFFF));
					pn = 24'($urandom_range(0, 24'hFFFFFF));
					mv = 24'($urandom_range(1, 24'hFFFFFF));
				end
			endcase
			set_config(sp, pn, mv);
			if (ph == PHASES - 1)
				idle_on = 1'b0;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (ph == 3 && i == 20)
					hold_req = 1'b1;
				sel = $urandom_range(0, 9);
				if (sel < 2) begin
					send_word($urandom, $urandom);
				end else begin
					if (sel == 2)
						true_ang = $urandom;
					rate_v = int'($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
					noise_v = int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
					true_ang = true_ang + (rate_v >>> 8);
					send_word(true_ang + noise_v, rate_v);
				end
			end
		end

		s_tvalid <= 1'b0;
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
